// ===== rtl/cts_pkg.sv =====
`default_nettype none
package cts_pkg;
    localparam int MAX_TRACKS = 16;
    localparam int SLOT_BITS  = $clog2(MAX_TRACKS);
    localparam int ID_BITS    = 10;
    localparam int COORD_BITS = 12;
    localparam int SPEED_BITS = 10;
    localparam int TS_BITS    = 32;
    localparam int NUM_BITS   = 40;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_RADIUS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_LOW    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_HIGH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_LOW     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXIT_HIGH    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_NUM    = 3'd6;

    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_EOF    = 1'b1;

    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    // controller to datapath
    typedef struct packed {
        logic                 load;      // capture input item, compute centre
        logic                 visit;     // test and update slot slot_idx
        logic                 alloc;     // allocate new track
        logic                 div_start; // start speed divide for slot_idx
        logic                 eof;       // end-of-frame sweep
        logic                 out_load;  // load output register
        logic                 out_new;
        logic                 out_last;
        logic [SLOT_BITS-1:0] slot_idx;
    } cts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_eof;
        logic hit;       // slot slot_idx matches
        logic div_done;
    } cts_stat_t;
endpackage
`default_nettype wire

// ===== rtl/centroid_tracker_speed_timer_unit.sv =====
`default_nettype none
// channel  | ports                          | direction
// s_       | s_valid/s_ready, box item      | in
// m_       | m_valid/m_ready, result        | out
// cfg_     | cfg_valid/cfg_ready, register  | in
// An end-of-frame item is decoded and then sweeps the table. A detection is decoded,
// then matched against all 16 slots; with no match a new track is allocated, else the
// slots are scanned up to the last match with a bit-serial 40-bit speed divide per match.
// A stalled result holds the scan; s_ready stays low until the item is done.
// Reset is synchronous; the track table needs no clearing pass.
module centroid_tracker_speed_timer_unit (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic [cts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cts_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_command,
    input  wire logic [cts_pkg::COORD_BITS-1:0] s_box_x,
    input  wire logic [cts_pkg::COORD_BITS-1:0] s_box_y,
    input  wire logic [cts_pkg::COORD_BITS-1:0] s_box_w,
    input  wire logic [cts_pkg::COORD_BITS-1:0] s_box_h,
    input  wire logic [cts_pkg::TS_BITS-1:0]    s_timestamp,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic [cts_pkg::ID_BITS-1:0]    m_track_id,
    output logic      m_new_object,
    output logic      m_table_full,
    output logic [cts_pkg::SPEED_BITS-1:0] m_speed,
    output logic      m_over_limit,
    output logic      m_passed_exit,
    output logic      m_last
);
    cts_pkg::cts_cmd_t  cmd;
    cts_pkg::cts_stat_t stat;

    assign cfg_ready = 1'b1;

    cts_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat)
    );

    cts_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_command(s_command), .s_box_x(s_box_x), .s_box_y(s_box_y),
        .s_box_w(s_box_w), .s_box_h(s_box_h), .s_timestamp(s_timestamp),
        .m_track_id(m_track_id), .m_new_object(m_new_object),
        .m_table_full(m_table_full), .m_speed(m_speed),
        .m_over_limit(m_over_limit), .m_passed_exit(m_passed_exit), .m_last(m_last)
    );
endmodule
`default_nettype wire

// ===== rtl/cts_divider.sv =====
`default_nettype none
module cts_divider (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [cts_pkg::NUM_BITS-1:0]   dividend,
    input  wire logic [cts_pkg::TS_BITS-1:0]    divisor,
    output logic                                done,
    output logic [cts_pkg::SPEED_BITS-1:0]      quotient
);
    localparam int CNT_BITS = $clog2(cts_pkg::NUM_BITS + 1);

    logic [cts_pkg::NUM_BITS-1:0] num_reg, num_next;
    logic [cts_pkg::TS_BITS:0]    rem_reg, rem_next;
    logic [cts_pkg::TS_BITS-1:0]  den_reg, den_next;
    logic [cts_pkg::NUM_BITS-1:0] q_reg, q_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [cts_pkg::TS_BITS:0]    shifted;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[cts_pkg::TS_BITS-1:0], num_reg[cts_pkg::NUM_BITS-1]};
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CNT_BITS'(cts_pkg::NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring division, one quotient bit a cycle
            num_next = {num_reg[cts_pkg::NUM_BITS-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = shifted - {1'b0, den_reg};
                q_next   = {q_reg[cts_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[cts_pkg::NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    always_comb begin
        if (den_reg == '0)
            quotient = '0;
        else if (q_reg > cts_pkg::NUM_BITS'(cts_pkg::SPEED_MAX))
            quotient = cts_pkg::SPEED_MAX;
        else
            quotient = q_reg[cts_pkg::SPEED_BITS-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/cts_datapath.sv =====
`default_nettype none
module cts_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cts_pkg::cts_cmd_t                 cmd,
    output cts_pkg::cts_stat_t                     stat,
    input  wire logic                              cfg_valid,
    input  wire logic [cts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [cts_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              s_command,
    input  wire logic [cts_pkg::COORD_BITS-1:0]    s_box_x,
    input  wire logic [cts_pkg::COORD_BITS-1:0]    s_box_y,
    input  wire logic [cts_pkg::COORD_BITS-1:0]    s_box_w,
    input  wire logic [cts_pkg::COORD_BITS-1:0]    s_box_h,
    input  wire logic [cts_pkg::TS_BITS-1:0]       s_timestamp,
    output logic [cts_pkg::ID_BITS-1:0]            m_track_id,
    output logic                                   m_new_object,
    output logic                                   m_table_full,
    output logic [cts_pkg::SPEED_BITS-1:0]         m_speed,
    output logic                                   m_over_limit,
    output logic                                   m_passed_exit,
    output logic                                   m_last
);
    localparam int CW = cts_pkg::COORD_BITS;
    localparam int N  = cts_pkg::MAX_TRACKS;

    logic [9:0]  radius_reg;
    logic [CW-1:0] entry_lo_reg, entry_hi_reg, exit_lo_reg, exit_hi_reg;
    logic [cts_pkg::SPEED_BITS-1:0] limit_reg;
    logic [cts_pkg::NUM_BITS-1:0]   num_reg;

    logic [N-1:0] valid_reg, seen_reg;
    logic [cts_pkg::ID_BITS-1:0] tid_reg [N];
    logic [CW-1:0] cx_s_reg [N];
    logic [CW-1:0] cy_s_reg [N];
    logic [cts_pkg::TS_BITS-1:0] entry_reg [N];
    logic [cts_pkg::TS_BITS-1:0] elapsed_reg [N];
    logic [N-1:0] passed_reg;
    logic [cts_pkg::ID_BITS-1:0] next_id_reg;

    logic          cmd_reg;
    logic [CW-1:0] cx_reg, cy_reg, y_reg;
    logic [cts_pkg::TS_BITS-1:0] ts_reg;
    logic [19:0]   r2_reg;

    logic [CW+1:0] cx_sum, cy_sum;
    logic [CW:0]   cx_full, cy_full;
    logic [CW-1:0] sel_x, sel_y;
    logic [CW:0]   dx, dy;
    logic [CW-1:0] adx, ady;
    logic [2*CW-1:0] sqx, sqy;
    logic [2*CW:0] d2;
    logic          in_entry, in_exit, hit;
    logic [cts_pkg::TS_BITS-1:0] cur_elapsed;

    logic          have_free;
    logic [cts_pkg::SLOT_BITS-1:0] free_idx;

    logic div_done;
    logic [cts_pkg::SPEED_BITS-1:0] quotient;

    logic [cts_pkg::ID_BITS-1:0] hit_id_reg;
    logic hit_passed_reg, full_reg;
    logic [cts_pkg::ID_BITS-1:0] new_id_reg;

    // 2*pos + size needs two bits over the coordinate width
    assign cx_sum  = {1'b0, s_box_x, 1'b0} + {2'b00, s_box_w};
    assign cy_sum  = {1'b0, s_box_y, 1'b0} + {2'b00, s_box_h};
    assign cx_full = cx_sum[CW+1:1];
    assign cy_full = cy_sum[CW+1:1];

    assign sel_x = cx_s_reg[cmd.slot_idx];
    assign sel_y = cy_s_reg[cmd.slot_idx];
    assign dx  = {1'b0, cx_reg} - {1'b0, sel_x};
    assign dy  = {1'b0, cy_reg} - {1'b0, sel_y};
    assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    assign sqx = {CW'(0), adx} * {CW'(0), adx};
    assign sqy = {CW'(0), ady} * {CW'(0), ady};
    assign d2  = {1'b0, sqx} + {1'b0, sqy};
    assign hit = valid_reg[cmd.slot_idx] && (d2 < (2*CW+1)'(r2_reg));
    assign in_entry = (y_reg >= entry_lo_reg) && (y_reg <= entry_hi_reg);
    assign in_exit  = (y_reg >= exit_lo_reg) && (y_reg <= exit_hi_reg);
    assign cur_elapsed = in_exit
        ? ts_reg - (in_entry ? ts_reg : entry_reg[cmd.slot_idx])
        : elapsed_reg[cmd.slot_idx];

    always_comb begin
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                have_free = 1'b1;
                free_idx  = cts_pkg::SLOT_BITS'(i);
            end
        end
    end

    cts_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(num_reg), .divisor(elapsed_reg[cmd.slot_idx]),
        .done(div_done), .quotient(quotient)
    );

    assign stat.is_eof   = (cmd_reg == cts_pkg::CMD_EOF);
    assign stat.hit      = hit;
    assign stat.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 10'd70;
            entry_lo_reg <= CW'(410);
            entry_hi_reg <= CW'(430);
            exit_lo_reg  <= CW'(235);
            exit_hi_reg  <= CW'(255);
            limit_reg    <= cts_pkg::SPEED_BITS'(80);
            num_reg      <= cts_pkg::NUM_BITS'(214150000);
            valid_reg    <= '0;
            seen_reg     <= '0;
            next_id_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    cts_pkg::REG_MATCH_RADIUS: radius_reg   <= cfg_data[9:0];
                    cts_pkg::REG_ENTRY_LOW:    entry_lo_reg <= cfg_data[CW-1:0];
                    cts_pkg::REG_ENTRY_HIGH:   entry_hi_reg <= cfg_data[CW-1:0];
                    cts_pkg::REG_EXIT_LOW:     exit_lo_reg  <= cfg_data[CW-1:0];
                    cts_pkg::REG_EXIT_HIGH:    exit_hi_reg  <= cfg_data[CW-1:0];
                    cts_pkg::REG_SPEED_LIMIT:  limit_reg    <= cfg_data[9:0];
                    cts_pkg::REG_SPEED_NUM:    num_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.eof) begin
                valid_reg <= valid_reg & seen_reg;
                seen_reg  <= '0;
            end
            if (cmd.visit && hit)
                seen_reg[cmd.slot_idx] <= 1'b1;
            if (cmd.alloc) begin
                next_id_reg <= next_id_reg + 1'b1;
                if (have_free) begin
                    valid_reg[free_idx] <= 1'b1;
                    seen_reg[free_idx]  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_command;
            cx_reg  <= cx_full[CW] ? {CW{1'b1}} : cx_full[CW-1:0];
            cy_reg  <= cy_full[CW] ? {CW{1'b1}} : cy_full[CW-1:0];
            y_reg   <= s_box_y;
            ts_reg  <= s_timestamp;
            r2_reg  <= {10'b0, radius_reg} * {10'b0, radius_reg};
        end
        if (cmd.visit && hit) begin
            cx_s_reg[cmd.slot_idx] <= cx_reg;
            cy_s_reg[cmd.slot_idx] <= cy_reg;
            if (in_entry)
                entry_reg[cmd.slot_idx] <= ts_reg;
            elapsed_reg[cmd.slot_idx] <= cur_elapsed;
            if (y_reg < exit_lo_reg)
                passed_reg[cmd.slot_idx] <= 1'b1;
            hit_id_reg     <= tid_reg[cmd.slot_idx];
            hit_passed_reg <= passed_reg[cmd.slot_idx] || (y_reg < exit_lo_reg);
        end
        if (cmd.alloc) begin
            new_id_reg <= next_id_reg;
            full_reg   <= !have_free;
            if (have_free) begin
                tid_reg[free_idx]     <= next_id_reg;
                cx_s_reg[free_idx]    <= cx_reg;
                cy_s_reg[free_idx]    <= cy_reg;
                entry_reg[free_idx]   <= '0;
                elapsed_reg[free_idx] <= '0;
                passed_reg[free_idx]  <= 1'b0;
            end
        end
        if (cmd.out_load) begin
            m_last <= cmd.out_last;
            if (cmd.out_new) begin
                m_track_id    <= new_id_reg;
                m_new_object  <= 1'b1;
                m_table_full  <= full_reg;
                m_speed       <= '0;
                m_over_limit  <= 1'b0;
                m_passed_exit <= 1'b0;
            end else begin
                m_track_id    <= hit_id_reg;
                m_new_object  <= 1'b0;
                m_table_full  <= 1'b0;
                m_speed       <= quotient;
                m_over_limit  <= quotient > limit_reg;
                m_passed_exit <= hit_passed_reg;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cts_controller.sv =====
`default_nettype none
module cts_controller (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cts_pkg::cts_cmd_t  cmd,
    input  wire cts_pkg::cts_stat_t stat
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DECO  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_ALLOC = 3'd5;
    localparam logic [2:0] ST_NEMIT = 3'd6;
    localparam logic [2:0] ST_MARK  = 3'd7;

    localparam int SB = cts_pkg::SLOT_BITS;
    localparam int N  = cts_pkg::MAX_TRACKS;

    logic [2:0]    state_reg, state_next;
    logic [SB-1:0] idx_reg, idx_next;
    logic [N-1:0]  mask_reg, mask_next;   // slots that match this item
    logic          pend_reg, pend_next;   // hit waiting for output register
    logic          mv_reg, mv_next;
    logic          is_end;
    logic          out_free;
    logic          more_hits;

    assign is_end   = (idx_reg == SB'(cts_pkg::MAX_TRACKS - 1));
    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !pend_reg;
    assign m_valid  = mv_reg;

    always_comb begin
        more_hits = 1'b0;
        for (int j = 0; j < N; j++) begin
            if (mask_reg[j] && (SB'(j) > idx_reg))
                more_hits = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        pend_next  = pend_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.slot_idx = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECO;
                end
            end
            ST_DECO: begin
                idx_next  = '0;
                mask_next = '0;
                if (stat.is_eof) begin
                    cmd.eof    = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                // find every matching slot first so the last result is known
                mask_next[idx_reg] = stat.hit;
                if (is_end) begin
                    idx_next   = '0;
                    state_next = (mask_next == '0) ? ST_ALLOC : ST_SCAN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                cmd.visit = 1'b1;
                if (stat.hit) begin
                    state_next = ST_DIV;
                end else if (is_end) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIV: begin
                // elapsed of this slot now settled
                cmd.div_start = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.div_done) pend_next = 1'b1;
                if (pend_reg || stat.div_done) begin
                    if (out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = !more_hits;
                        mv_next      = 1'b1;
                        pend_next    = 1'b0;
                        if (!more_hits) begin
                            state_next = ST_IDLE;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = ST_NEMIT;
            end
            ST_NEMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_new  = 1'b1;
                    cmd.out_last = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            mask_reg  <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE) else $error("load outside idle");
    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free) else $error("output overwritten");
    a_alloc_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |-> mask_reg == '0) else $error("alloc after hit");
`endif
endmodule
`default_nettype wire
